// File: hw/rtl/ntcs_pkg.sv
package ntcs_pkg;

    localparam int MAX_TRIANGLES = 256;
    localparam int IDX_W         = $clog2(MAX_TRIANGLES);
    localparam int CNT_W         = $clog2(MAX_TRIANGLES + 1);
    localparam int COORD_W       = 16;
    localparam int SUM_W         = COORD_W + 2;
    localparam int DIFF_W        = SUM_W + 1;
    localparam int ABS_W         = SUM_W;
    localparam int SQ_W          = 2 * ABS_W;
    localparam int ACC_W         = SQ_W + 2;
    localparam int DIST_W        = 40;
    localparam int ENTRY_W       = 3 * SUM_W;

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_QUERY = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef struct packed {
        logic             load_vtx;
        logic             clear;
        logic             query_start;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             out_load;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] tri_count;
        logic             pipe_busy;
    } status_t;

endpackage

// File: hw/rtl/ntcs_ctrl.sv
module ntcs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [1:0]        func,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  ntcs_pkg::status_t status,
    output ntcs_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t                        state_reg;
    logic [ntcs_pkg::IDX_W-1:0]    scan_cnt_reg;
    logic                          out_valid_reg;
    logic                          accept;
    logic [ntcs_pkg::IDX_W-1:0]    last_idx;
    logic                          out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;
    assign last_idx = ntcs_pkg::IDX_W'(status.tri_count - ntcs_pkg::CNT_W'(1));

    always_comb
    begin
        cmd             = '0;
        cmd.load_vtx    = accept && (func == ntcs_pkg::FUNC_LOAD);
        cmd.clear       = accept && (func == ntcs_pkg::FUNC_CLEAR);
        cmd.query_start = accept && (func == ntcs_pkg::FUNC_QUERY);
        cmd.rd_en       = (state_reg == ST_SCAN);
        cmd.rd_addr     = scan_cnt_reg;
        cmd.out_load    = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !cmd.out_load)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd.query_start)
                    begin
                        scan_cnt_reg <= '0;
                        if (status.tri_count == '0)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN:
                begin
                    if (scan_cnt_reg == last_idx)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    else
                    begin
                        scan_cnt_reg <= scan_cnt_reg + ntcs_pkg::IDX_W'(1);
                    end
                end
                ST_DRAIN:
                begin
                    if (!status.pipe_busy)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> ({1'b0, cmd.rd_addr} < status.tri_count))
        else $error("scan address beyond stored triangles");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || m_tready))
        else $error("result overwritten before taken");

    a_scan_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.query_start && status.tri_count != '0) |=> cmd.rd_en)
        else $error("query with stored triangles did not start scan");

    a_busy_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE) |-> !status.pipe_busy)
        else $error("result formed while pipeline busy");

endmodule

// File: hw/rtl/ntcs_datapath.sv
module ntcs_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ntcs_pkg::cmd_t                      cmd,
    output ntcs_pkg::status_t                   status,
    input  logic signed [ntcs_pkg::COORD_W-1:0] coord_x,
    input  logic signed [ntcs_pkg::COORD_W-1:0] coord_y,
    input  logic signed [ntcs_pkg::COORD_W-1:0] coord_z,
    output logic                                found,
    output logic [ntcs_pkg::IDX_W-1:0]          nearest_index,
    output logic [ntcs_pkg::DIST_W-1:0]         scaled_distance
);

    logic [ntcs_pkg::ENTRY_W-1:0]          mem [ntcs_pkg::MAX_TRIANGLES];

    logic [ntcs_pkg::CNT_W-1:0]            count_reg;
    logic [1:0]                            phase_reg;
    logic signed [ntcs_pkg::SUM_W-1:0]     partial_reg [3];
    logic signed [ntcs_pkg::SUM_W-1:0]     partial_next [3];
    logic signed [ntcs_pkg::SUM_W-1:0]     coord_ext [3];
    logic signed [ntcs_pkg::SUM_W-1:0]     p3_reg [3];
    logic signed [ntcs_pkg::SUM_W-1:0]     p3_next [3];

    logic [ntcs_pkg::ENTRY_W-1:0]          mem_q_reg;
    logic [ntcs_pkg::ABS_W-1:0]            absd_reg [3];
    logic [ntcs_pkg::ABS_W-1:0]            absd_next [3];
    logic [ntcs_pkg::SQ_W-1:0]             sq_reg [3];
    logic [ntcs_pkg::ACC_W-1:0]            dist_reg;
    logic [ntcs_pkg::ACC_W-1:0]            best_dist_reg;
    logic [ntcs_pkg::IDX_W-1:0]            best_idx_reg;
    logic                                  first_reg;
    logic [ntcs_pkg::IDX_W-1:0]            idx1_reg;
    logic [ntcs_pkg::IDX_W-1:0]            idx2_reg;
    logic [ntcs_pkg::IDX_W-1:0]            idx3_reg;
    logic [ntcs_pkg::IDX_W-1:0]            idx4_reg;
    logic                                  v1_reg;
    logic                                  v2_reg;
    logic                                  v3_reg;
    logic                                  v4_reg;

    logic                                  found_reg;
    logic [ntcs_pkg::IDX_W-1:0]            index_reg;
    logic [ntcs_pkg::DIST_W-1:0]           sdist_reg;

    logic                                  tri_done;
    logic                                  table_full;
    logic                                  take_best;

    assign coord_ext[0] = ntcs_pkg::SUM_W'(coord_x);
    assign coord_ext[1] = ntcs_pkg::SUM_W'(coord_y);
    assign coord_ext[2] = ntcs_pkg::SUM_W'(coord_z);

    assign tri_done   = cmd.load_vtx && (phase_reg == 2'd2);
    assign table_full = (count_reg == ntcs_pkg::CNT_W'(ntcs_pkg::MAX_TRIANGLES));

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            partial_next[a] = partial_reg[a] + coord_ext[a];
            p3_next[a]      = (coord_ext[a] <<< 1) + coord_ext[a];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            phase_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                partial_reg[a] <= '0;
            end
        end
        else if (cmd.clear || tri_done)
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (!table_full)
            begin
                count_reg <= count_reg + ntcs_pkg::CNT_W'(1);
            end
            phase_reg <= '0;
            for (int a = 0; a < 3; a++)
            begin
                partial_reg[a] <= '0;
            end
        end
        else if (cmd.load_vtx)
        begin
            phase_reg <= phase_reg + 2'd1;
            for (int a = 0; a < 3; a++)
            begin
                partial_reg[a] <= partial_next[a];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (tri_done && !table_full)
        begin
            mem[count_reg[ntcs_pkg::IDX_W-1:0]] <= {partial_next[2], partial_next[1],
                                                    partial_next[0]};
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[cmd.rd_addr];
        end
    end

    always_comb
    begin
        logic signed [ntcs_pkg::DIFF_W-1:0] d;
        logic [ntcs_pkg::DIFF_W-1:0]        m;
        for (int a = 0; a < 3; a++)
        begin
            d = ntcs_pkg::DIFF_W'($signed(mem_q_reg[a*ntcs_pkg::SUM_W +: ntcs_pkg::SUM_W]))
                - ntcs_pkg::DIFF_W'(p3_reg[a]);
            m = d[ntcs_pkg::DIFF_W-1] ? ntcs_pkg::DIFF_W'(-d) : ntcs_pkg::DIFF_W'(d);
            absd_next[a] = m[ntcs_pkg::ABS_W-1:0];
        end
    end

    assign take_best = v4_reg && (first_reg || (dist_reg < best_dist_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            first_reg <= 1'b1;
        end
        else
        begin
            v1_reg <= cmd.rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            if (cmd.query_start)
            begin
                first_reg <= 1'b1;
            end
            else if (v4_reg)
            begin
                first_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            for (int a = 0; a < 3; a++)
            begin
                p3_reg[a] <= p3_next[a];
            end
        end
        idx1_reg <= cmd.rd_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        idx4_reg <= idx3_reg;
        for (int a = 0; a < 3; a++)
        begin
            absd_reg[a] <= absd_next[a];
            sq_reg[a]   <= absd_reg[a] * absd_reg[a];
        end
        dist_reg <= ntcs_pkg::ACC_W'(sq_reg[0]) + ntcs_pkg::ACC_W'(sq_reg[1])
                    + ntcs_pkg::ACC_W'(sq_reg[2]);
        if (take_best)
        begin
            best_dist_reg <= dist_reg;
            best_idx_reg  <= idx4_reg;
        end
        if (cmd.out_load)
        begin
            found_reg <= (count_reg != '0);
            index_reg <= (count_reg != '0) ? best_idx_reg : '0;
            sdist_reg <= (count_reg != '0) ? ntcs_pkg::DIST_W'(best_dist_reg) : '0;
        end
    end

    assign status.tri_count = count_reg;
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg || v4_reg;
    assign found            = found_reg;
    assign nearest_index    = index_reg;
    assign scaled_distance  = sdist_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ntcs_pkg::CNT_W'(ntcs_pkg::MAX_TRIANGLES))
        else $error("triangle count beyond table depth");

    a_phase_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != 2'd3)
        else $error("vertex phase out of range");

    a_tri_step: assert property (@(posedge clk) disable iff (!rst_n)
        (tri_done && !table_full && !cmd.clear)
        |=> (count_reg == $past(count_reg) + ntcs_pkg::CNT_W'(1)))
        else $error("completed triangle not counted");

endmodule

// File: hw/rtl/nearest_triangle_centroid_search.sv
// load, clear and unused items produce no output transaction
// query: result becomes valid after all N stored triangles are scanned, N = stored triangles
// throughput: the scan reads one table entry per cycle from a single memory port
// a query with an empty table skips the scan and answers with found low, index and distance zero
// reset: async active low, clears triangle count, vertex phase, partial sums and control
// table contents are not cleared and are undefined until written
module nearest_triangle_centroid_search (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,  // coord_x, coord_y, coord_z
    input  logic [1:0]  s_tuser,  // func
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,  // nearest_index, scaled_distance
    output logic        m_tuser   // found
);

    ntcs_pkg::cmd_t    cmd;
    ntcs_pkg::status_t status;
    logic [ntcs_pkg::IDX_W-1:0]  nearest_index;
    logic [ntcs_pkg::DIST_W-1:0] scaled_distance;
    logic                        found;

    ntcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .func     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ntcs_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .status          (status),
        .coord_x         (s_tdata[15:0]),
        .coord_y         (s_tdata[31:16]),
        .coord_z         (s_tdata[47:32]),
        .found           (found),
        .nearest_index   (nearest_index),
        .scaled_distance (scaled_distance)
    );

    assign m_tdata = {scaled_distance, nearest_index};
    assign m_tuser = found;

endmodule
